@@ rtl/tcsp_pkg.sv @@
// ----------------------------------------------------------------------------
// tcsp_pkg
// Shared types and constants for the telnet command stream parser.
// ----------------------------------------------------------------------------
package tcsp_pkg;

   // fixed record field widths
   localparam int START_W = 11;
   localparam int SPAN_W  = 12;
   localparam int LIMIT_W = 9;

   // telnet codes
   localparam logic [7:0] IAC_CODE  = 8'd255;
   localparam logic [7:0] SB_CODE   = 8'd250;
   localparam logic [7:0] WILL_CODE = 8'd251;
   localparam logic [7:0] CMD_FIRST = 8'd236;
   localparam logic [7:0] CMD_LAST  = 8'd249;

   // known option limit after reset
   localparam logic [LIMIT_W-1:0] LIMIT_RESET = 9'd41;

   // csr decode: word select bit of the address
   localparam logic CSR_LIMIT_SEL = 1'b0;

   // record queue between parser and output stage
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = 2;

   typedef enum logic [2:0] {
      KIND_DATA        = 3'd0,
      KIND_COMMAND     = 3'd1,
      KIND_NEGOTIATION = 3'd2,
      KIND_SUBOPTION   = 3'd3,
      KIND_TRUNCATED   = 3'd4
   } kind_type;

   typedef enum logic [2:0] {
      MODE_DATA,
      MODE_IAC,
      MODE_NEG,
      MODE_SB_OPT,
      MODE_SB_REQ,
      MODE_SB_VAL
   } mode_type;

   typedef struct packed {
      kind_type            kind;
      logic [START_W-1:0]  start;
      logic [SPAN_W-1:0]   span;
      logic [7:0]          cmd;
      logic [7:0]          opt;
      logic                known;
      logic                send;
      logic                last;
   } rec_type;

   // one queue entry: all records caused by one request
   typedef struct packed {
      logic    two;
      rec_type first;
      rec_type second;
   } pair_type;

endpackage

@@ rtl/tcsp_front.sv @@
// ----------------------------------------------------------------------------
// tcsp_front
// Byte parser: tracks the telnet mode and builds up to two records per byte.
// ----------------------------------------------------------------------------
module tcsp_front
   import tcsp_pkg::*;
#(
   parameter int MAX_PACKET_BYTES = 2048
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               in_valid,
   output logic               in_ready,
   input  logic [7:0]         in_data,
   input  logic               in_last,
   input  logic [LIMIT_W-1:0] limit,
   input  logic               queue_full,
   output logic               push,
   output pair_type           push_entry
);

   localparam int POS_W = $clog2(MAX_PACKET_BYTES);
   localparam int LEN_W = $clog2(MAX_PACKET_BYTES + 1);
   localparam logic [POS_W-1:0] POS_MAX = POS_W'(MAX_PACKET_BYTES - 1);
   localparam logic [LEN_W-1:0] LEN_MAX = LEN_W'(MAX_PACKET_BYTES);

   mode_type         mode_ff, mode_in;
   logic [POS_W-1:0] pos_ff, pos_in;
   logic [POS_W-1:0] run_start_ff, run_start_in;
   logic [LEN_W-1:0] run_len_ff, run_len_in;
   logic [7:0]       pending_ff, pending_in;
   logic [POS_W-1:0] cmd_start_ff, cmd_start_in;
   logic [7:0]       sub_opt_ff, sub_opt_in;
   logic             sub_req_ff, sub_req_in;
   logic [LEN_W-1:0] val_len_ff, val_len_in;

   rec_type          rec_buf [2];
   logic [1:0]       rec_cnt;
   logic             accept;

   function automatic logic [LEN_W-1:0] sat_len(input logic [LEN_W-1:0] v);
      return (v >= LEN_MAX) ? LEN_MAX : v + LEN_W'(1);
   endfunction

   function automatic rec_type mk_rec(input kind_type k, input logic [POS_W-1:0] s,
                                      input logic [LEN_W-1:0] n, input logic [7:0] c,
                                      input logic [7:0] o, input logic kn,
                                      input logic sd);
      rec_type r;
      r.kind  = k;
      r.start = START_W'(s);
      r.span  = SPAN_W'(n);
      r.cmd   = c;
      r.opt   = o;
      r.known = kn;
      r.send  = sd;
      r.last  = 1'b0;
      return r;
   endfunction

   assign in_ready = !queue_full;
   assign accept   = in_valid && in_ready;
   assign push     = accept && (rec_cnt != 2'd0);

   always_comb begin
      mode_in      = mode_ff;
      pos_in       = pos_ff;
      run_start_in = run_start_ff;
      run_len_in   = run_len_ff;
      pending_in   = pending_ff;
      cmd_start_in = cmd_start_ff;
      sub_opt_in   = sub_opt_ff;
      sub_req_in   = sub_req_ff;
      val_len_in   = val_len_ff;
      rec_buf[0]   = '0;
      rec_buf[1]   = '0;
      rec_cnt      = 2'd0;

      case (mode_ff)
         MODE_IAC: begin
            if (in_data == IAC_CODE) begin
               // escaped 255 joins the run
               if (run_len_ff == '0) begin
                  run_start_in = cmd_start_ff;
               end
               run_len_in = sat_len(run_len_ff);
               mode_in    = MODE_DATA;
            end else begin
               if (run_len_in != '0) begin
                  rec_buf[rec_cnt[0]] = mk_rec(KIND_DATA, run_start_in, run_len_in,
                                               8'd0, 8'd0, 1'b0, 1'b0);
                  rec_cnt    = rec_cnt + 2'd1;
                  run_len_in = '0;
               end
               if (in_data inside {[CMD_FIRST:CMD_LAST]}) begin
                  rec_buf[rec_cnt[0]] = mk_rec(KIND_COMMAND, cmd_start_ff, '0,
                                               in_data, 8'd0, 1'b0, 1'b0);
                  rec_cnt = rec_cnt + 2'd1;
                  mode_in = MODE_DATA;
               end else if (in_data >= WILL_CODE) begin
                  pending_in = in_data;
                  mode_in    = MODE_NEG;
               end else if (in_data == SB_CODE) begin
                  pending_in = SB_CODE;
                  mode_in    = MODE_SB_OPT;
               end else begin
                  // unknown code opens a new data run
                  run_start_in = pos_ff;
                  run_len_in   = LEN_W'(1);
                  mode_in      = MODE_DATA;
               end
            end
         end
         MODE_NEG: begin
            rec_buf[rec_cnt[0]] = mk_rec(KIND_NEGOTIATION, cmd_start_ff, '0, pending_ff,
                                         in_data, {1'b0, in_data} < limit, 1'b0);
            rec_cnt = rec_cnt + 2'd1;
            mode_in = MODE_DATA;
         end
         MODE_SB_OPT: begin
            sub_opt_in = in_data;
            mode_in    = MODE_SB_REQ;
         end
         MODE_SB_REQ: begin
            sub_req_in = (in_data != 8'd0);
            val_len_in = '0;
            mode_in    = MODE_SB_VAL;
         end
         MODE_SB_VAL: begin
            if (in_data == IAC_CODE) begin
               rec_buf[rec_cnt[0]] = mk_rec(KIND_SUBOPTION, cmd_start_ff, val_len_ff,
                                            SB_CODE, sub_opt_ff,
                                            {1'b0, sub_opt_ff} < limit, sub_req_ff);
               rec_cnt      = rec_cnt + 2'd1;
               cmd_start_in = pos_ff;
               pending_in   = 8'd0;
               mode_in      = MODE_IAC;
            end else begin
               val_len_in = sat_len(val_len_ff);
            end
         end
         default: begin
            if (in_data == IAC_CODE) begin
               cmd_start_in = pos_ff;
               pending_in   = 8'd0;
               mode_in      = MODE_IAC;
            end else begin
               if (run_len_ff == '0) begin
                  run_start_in = pos_ff;
               end
               run_len_in = sat_len(run_len_ff);
               mode_in    = MODE_DATA;
            end
         end
      endcase

      if (in_last) begin
         if (mode_in == MODE_SB_VAL) begin
            rec_buf[rec_cnt[0]] = mk_rec(KIND_SUBOPTION, cmd_start_in, val_len_in,
                                         SB_CODE, sub_opt_in,
                                         {1'b0, sub_opt_in} < limit, sub_req_in);
            rec_cnt = rec_cnt + 2'd1;
         end else begin
            if (run_len_in != '0) begin
               rec_buf[rec_cnt[0]] = mk_rec(KIND_DATA, run_start_in, run_len_in,
                                            8'd0, 8'd0, 1'b0, 1'b0);
               rec_cnt = rec_cnt + 2'd1;
            end
            if (mode_in != MODE_DATA) begin
               rec_buf[rec_cnt[0]] = mk_rec(KIND_TRUNCATED, cmd_start_in, '0,
                                            pending_in, 8'd0, 1'b0, 1'b0);
               rec_cnt = rec_cnt + 2'd1;
            end
         end
         mode_in      = MODE_DATA;
         pos_in       = '0;
         run_start_in = '0;
         run_len_in   = '0;
         pending_in   = 8'd0;
         cmd_start_in = '0;
         sub_opt_in   = 8'd0;
         sub_req_in   = 1'b0;
         val_len_in   = '0;
      end else if (pos_ff < POS_MAX) begin
         pos_in = pos_ff + POS_W'(1);
      end
   end

   always_comb begin
      push_entry.two         = (rec_cnt == 2'd2);
      push_entry.first       = rec_buf[0];
      push_entry.first.last  = (rec_cnt != 2'd2);
      push_entry.second      = rec_buf[1];
      push_entry.second.last = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff      <= MODE_DATA;
         pos_ff       <= '0;
         run_start_ff <= '0;
         run_len_ff   <= '0;
         pending_ff   <= 8'd0;
         cmd_start_ff <= '0;
         sub_opt_ff   <= 8'd0;
         sub_req_ff   <= 1'b0;
         val_len_ff   <= '0;
      end else if (accept) begin
         mode_ff      <= mode_in;
         pos_ff       <= pos_in;
         run_start_ff <= run_start_in;
         run_len_ff   <= run_len_in;
         pending_ff   <= pending_in;
         cmd_start_ff <= cmd_start_in;
         sub_opt_ff   <= sub_opt_in;
         sub_req_ff   <= sub_req_in;
         val_len_ff   <= val_len_in;
      end
   end

endmodule

@@ rtl/tcsp_queue.sv @@
// ----------------------------------------------------------------------------
// tcsp_queue
// Short fifo of record pairs between the parser and the output stage.
// ----------------------------------------------------------------------------
module tcsp_queue
   import tcsp_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     push,
   input  pair_type push_entry,
   input  logic     pop,
   output pair_type head,
   output logic     empty,
   output logic     full
);

   pair_type            q_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QPTR_W:0]     cnt_ff, cnt_in;

   assign head  = q_ff[rd_ptr_ff];
   assign empty = (cnt_ff == '0);
   assign full  = (cnt_ff == (QPTR_W + 1)'(QUEUE_DEPTH));

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + QPTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + QPTR_W'(1) : rd_ptr_ff;
      case ({push, pop})
         2'b10:   cnt_in = cnt_ff + (QPTR_W + 1)'(1);
         2'b01:   cnt_in = cnt_ff - (QPTR_W + 1)'(1);
         default: cnt_in = cnt_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wr_ptr_ff] <= push_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

endmodule

@@ rtl/tcsp_back.sv @@
// ----------------------------------------------------------------------------
// tcsp_back
// Output stage: unpacks queued record pairs into one registered record a cycle while out_ready allows.
// ----------------------------------------------------------------------------
module tcsp_back
   import tcsp_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  pair_type head,
   input  logic     empty,
   output logic     pop,
   output logic     out_valid,
   input  logic     out_ready,
   output rec_type  out_rec
);

   logic    out_valid_ff, out_valid_in;
   rec_type out_rec_ff, out_rec_in;
   logic    hold_valid_ff, hold_valid_in;
   rec_type hold_rec_ff, hold_rec_in;
   logic    load;

   assign load      = !out_valid_ff || out_ready;
   assign out_valid = out_valid_ff;
   assign out_rec   = out_rec_ff;

   always_comb begin
      out_valid_in  = out_valid_ff;
      out_rec_in    = out_rec_ff;
      hold_valid_in = hold_valid_ff;
      hold_rec_in   = hold_rec_ff;
      pop           = 1'b0;
      if (load) begin
         if (hold_valid_ff) begin
            // second record of the previous pair goes first
            out_valid_in  = 1'b1;
            out_rec_in    = hold_rec_ff;
            hold_valid_in = 1'b0;
         end else if (!empty) begin
            pop           = 1'b1;
            out_valid_in  = 1'b1;
            out_rec_in    = head.first;
            hold_valid_in = head.two;
            hold_rec_in   = head.second;
         end else begin
            out_valid_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      out_rec_ff  <= out_rec_in;
      hold_rec_ff <= hold_rec_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         hold_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         hold_valid_ff <= hold_valid_in;
      end
   end

endmodule

@@ rtl/telnet_command_stream_parser.sv @@
// ----------------------------------------------------------------------------
// telnet_command_stream_parser
// Parses a telnet byte stream into data run, command, negotiation, suboption
// and truncated command records.
// ----------------------------------------------------------------------------
// path: the first record of an accepted request is registered in a queue entry,
//   then in the output register, and is then shown on rsp; output stalls can
//   hold it in the queue
// throughput: one request per cycle unless the 4-entry pair queue is full; rsp carries
//   one record per cycle while rsp_tready is high (two transfers for a two-record request)
// reset: synchronous, clears parser state, queue and output stage, and sets
//   known_option_limit back to 41
// ----------------------------------------------------------------------------
module telnet_command_stream_parser
   import tcsp_pkg::*;
#(
   parameter int MAX_PACKET_BYTES = 2048
) (
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] data_byte
   input  logic        req_tlast,   // last_byte
   // record channel
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [47:0] rsp_tdata,   // [10:0] start_position, [22:11] span_length,
                                    // [30:23] command_code, [38:31] option_code,
                                    // [39] option_known, [40] send_request, rest 0
   output logic [2:0]  rsp_tuser,   // [2:0] record_kind
   output logic        rsp_tlast,   // last_record
   // control and status registers
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   logic [LIMIT_W-1:0] limit_ff, limit_in;
   logic               csr_write;

   logic     q_push;
   pair_type q_push_entry;
   logic     q_pop;
   pair_type q_head;
   logic     q_empty;
   logic     q_full;
   rec_type  out_rec;

   // ---------------- csr: known option limit at byte address 0
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_prdata = (csr_paddr[2] == CSR_LIMIT_SEL) ? 32'(limit_ff) : 32'd0;

   always_comb begin
      limit_in = limit_ff;
      if (csr_write && (csr_paddr[2] == CSR_LIMIT_SEL)) begin
         limit_in = csr_pwdata[LIMIT_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff <= LIMIT_RESET;
      end else begin
         limit_ff <= limit_in;
      end
   end

   // ---------------- front: one byte a cycle while the queue is not full, builds the records of each byte
   tcsp_front #(
      .MAX_PACKET_BYTES (MAX_PACKET_BYTES)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (req_tvalid),
      .in_ready   (req_tready),
      .in_data    (req_tdata),
      .in_last    (req_tlast),
      .limit      (limit_ff),
      .queue_full (q_full),
      .push       (q_push),
      .push_entry (q_push_entry)
   );

   // ---------------- queue: decouples parsing from output stalls
   tcsp_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_entry (q_push_entry),
      .pop        (q_pop),
      .head       (q_head),
      .empty      (q_empty),
      .full       (q_full)
   );

   // ---------------- back: serializes record pairs onto rsp
   tcsp_back u_back (
      .clock     (clock),
      .reset     (reset),
      .head      (q_head),
      .empty     (q_empty),
      .pop       (q_pop),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_rec   (out_rec)
   );

   // record fields packed lowest first
   assign rsp_tdata = {7'd0, out_rec.send, out_rec.known, out_rec.opt, out_rec.cmd,
                       out_rec.span, out_rec.start};
   assign rsp_tuser = out_rec.kind;
   assign rsp_tlast = out_rec.last;

endmodule

@@ rtl/tcsp_checker.sv @@
// ----------------------------------------------------------------------------
// tcsp_checker
// Port-level checks for the telnet command stream parser.
// ----------------------------------------------------------------------------
module tcsp_checker
   import tcsp_pkg::*;
(
   input logic        clock,
   input logic        reset,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [47:0] rsp_tdata,
   input logic [2:0]  rsp_tuser,
   input logic        rsp_tlast
);

   // nothing comes out right after reset
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("record valid right after reset");

   // stalled record holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata)
         && $stable(rsp_tuser) && $stable(rsp_tlast))
      else $error("record changed while stalled");

   // a data run is never empty
   a_run_nonempty: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser == KIND_DATA) |-> rsp_tdata[22:11] != 12'd0)
      else $error("empty data run record");

   // simple commands carry no option, no span and a code in the command range
   a_cmd_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser == KIND_COMMAND) |->
         rsp_tdata[22:11] == 12'd0 && rsp_tdata[38:31] == 8'd0
         && rsp_tdata[30:23] >= CMD_FIRST && rsp_tdata[30:23] <= CMD_LAST)
      else $error("bad simple command record");

endmodule

bind telnet_command_stream_parser tcsp_checker u_tcsp_checker (.*);
